[hw/rtl/apsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants of the all-pairs shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int REQ_W    = 2;
  localparam int VTX_W    = 4;
  localparam int WEIGHT_W = 16;
  localparam int CNT_W    = 5;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [WEIGHT_W-1:0] NO_EDGE = 16'hFFFF;

  // register word indices, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_RUN  = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  typedef enum logic [REQ_W-1:0] {
    RSP_LOAD_ACK = 2'd0,
    RSP_RUN_DONE = 2'd1,
    RSP_READ     = 2'd2
  } rsp_e;

endpackage

[hw/rtl/apsp_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_req_if
// Request channel: load, run and read items.
// ----------------------------------------------------------------------------
interface apsp_req_if import apsp_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [VTX_W-1:0]    src_vertex;
  logic [VTX_W-1:0]    dst_vertex;
  logic [WEIGHT_W-1:0] edge_weight;

  modport source (
    output valid, req_type, src_vertex, dst_vertex, edge_weight,
    input  ready
  );

  modport sink (
    input  valid, req_type, src_vertex, dst_vertex, edge_weight,
    output ready
  );

endinterface

[hw/rtl/apsp_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_rsp_if
// Reply channel: load acknowledge, run done and read data items.
// ----------------------------------------------------------------------------
interface apsp_rsp_if import apsp_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    reply_kind;
  logic [WEIGHT_W-1:0] path_distance;
  logic [VTX_W-1:0]    next_vertex;

  modport source (
    output valid, reply_kind, path_distance, next_vertex,
    input  ready
  );

  modport sink (
    input  valid, reply_kind, path_distance, next_vertex,
    output ready
  );

endinterface

[hw/rtl/all_pairs_shortest_path_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_top
// Floyd-Warshall shortest paths with next-hop tracking over an on-chip table.
// ----------------------------------------------------------------------------
// Distances and next hops live in two synchronous memories of MAX_VERTICES^2
// entries with one write port; the distance memory has two read ports and
// the next-hop memory one. A load item's acknowledge can be taken in the
// next cycle; a read item waits in ST_RD_WAIT for its memory read before
// its reply. A run item holds off further items while it sweeps the table:
// for each intermediate and row, ST_ROW reads the row's entry toward the
// intermediate, ST_ROW_CAP captures it, then ST_SWEEP reads, compares and
// writes back one column per cycle. Entries must be loaded before a run or a
// read touches them; the memories are not cleared after reset.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_top import apsp_pkg::*; #(
  parameter int MAX_VERTICES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  apsp_req_if.sink          req_i,
  apsp_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int IW    = (VW > VTX_W) ? VW : VTX_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RD_WAIT = 6'b000010,
    ST_ROW     = 6'b000100,
    ST_ROW_CAP = 6'b001000,
    ST_SWEEP   = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                               input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_VERTICES + int'(c));
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] vc_q, vc_d;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
  assign vc_d   = cfg_we ? pwdata[CNT_W-1:0] : vc_q;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(vc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VERTEX_COUNT_RST;
    end else begin
      vc_q <= vc_d;
    end
  end

  logic          run_empty;
  logic [VW-1:0] last_idx;

  assign run_empty = (vc_q == '0);
  assign last_idx  = (int'(vc_q) > MAX_VERTICES) ? VW'(MAX_VERTICES - 1)
                                                 : VW'(vc_q - 5'd1);

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  state_e        state_q, state_d;
  logic [VW-1:0] u_q, u_d, v_q, v_d, w_q, w_d;
  logic          out_valid_q, out_valid_d;
  logic          in_fire, out_free, in_inside, in_diag;
  logic          rd_inside_q, rd_inside_d, rd_diag_q, rd_diag_d;

  logic [WEIGHT_W-1:0] dvu_q, dvu_d;
  logic [VTX_W-1:0]    hvu_q, hvu_d;

  logic [REQ_W-1:0]    kind_q, kind_d;
  logic [WEIGHT_W-1:0] dist_q, dist_d;
  logic [VTX_W-1:0]    hop_q, hop_d;

  // memory ports
  logic [AW-1:0]       ra, rb, waddr;
  logic                we;
  logic [WEIGHT_W-1:0] wdist;
  logic [VTX_W-1:0]    whop;
  logic [WEIGHT_W-1:0] rda_q, rdb_q;
  logic [VTX_W-1:0]    rha_q;

  logic [WEIGHT_W:0]   via;
  logic                relax;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire     = req_i.valid && req_i.ready;
  assign in_inside   = (int'(req_i.src_vertex) < MAX_VERTICES) &&
                       (int'(req_i.dst_vertex) < MAX_VERTICES);
  assign in_diag     = (req_i.src_vertex == req_i.dst_vertex);

  assign via   = {1'b0, dvu_q} + {1'b0, rda_q};
  assign relax = ({1'b0, rdb_q} > via);

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.reply_kind    = kind_q;
  assign rsp_o.path_distance = dist_q;
  assign rsp_o.next_vertex   = hop_q;

  always_comb begin
    state_d     = state_q;
    u_d         = u_q;
    v_d         = v_q;
    w_d         = w_q;
    dvu_d       = dvu_q;
    hvu_d       = hvu_q;
    rd_inside_d = rd_inside_q;
    rd_diag_d   = rd_diag_q;
    kind_d      = kind_q;
    dist_d      = dist_q;
    hop_d       = hop_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ra          = cell_addr(IW'(req_i.src_vertex), IW'(req_i.dst_vertex));
    rb          = cell_addr(IW'(v_q), IW'(w_q));
    we          = 1'b0;
    waddr       = cell_addr(IW'(req_i.src_vertex), IW'(req_i.dst_vertex));
    wdist       = (req_i.edge_weight == '0) ? NO_EDGE : req_i.edge_weight;
    whop        = req_i.dst_vertex;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req_e'(req_i.req_type))
            REQ_LOAD: begin
              we          = in_inside;
              out_valid_d = 1'b1;
              kind_d      = RSP_LOAD_ACK;
              dist_d      = '0;
              hop_d       = '0;
            end
            REQ_RUN: begin
              u_d     = '0;
              v_d     = '0;
              state_d = run_empty ? ST_DONE : ST_ROW;
            end
            REQ_READ: begin
              rd_inside_d = in_inside;
              rd_diag_d   = in_diag;
              state_d     = ST_RD_WAIT;
            end
            default: ;  // drop unknown request
          endcase
        end
      end
      ST_RD_WAIT: begin
        out_valid_d = 1'b1;
        kind_d      = RSP_READ;
        dist_d      = rd_diag_q ? '0 : (rd_inside_q ? rda_q : NO_EDGE);
        hop_d       = rd_inside_q ? rha_q : '0;
        state_d     = ST_IDLE;
      end
      ST_ROW: begin
        ra      = cell_addr(IW'(v_q), IW'(u_q));
        state_d = ST_ROW_CAP;
      end
      ST_ROW_CAP: begin
        // hold D[v][u] for the whole row, issue first column
        dvu_d   = rda_q;
        hvu_d   = rha_q;
        w_d     = '0;
        ra      = cell_addr(IW'(u_q), '0);
        rb      = cell_addr(IW'(v_q), '0);
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        we    = relax;
        waddr = cell_addr(IW'(v_q), IW'(w_q));
        wdist = via[WEIGHT_W-1:0];
        whop  = hvu_q;
        if (w_q != last_idx) begin
          w_d = w_q + 1'b1;
          ra  = cell_addr(IW'(u_q), IW'(w_d));
          rb  = cell_addr(IW'(v_q), IW'(w_d));
        end else if (v_q != last_idx) begin
          v_d     = v_q + 1'b1;
          state_d = ST_ROW;
        end else if (u_q != last_idx) begin
          v_d     = '0;
          u_d     = u_q + 1'b1;
          state_d = ST_ROW;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        kind_d      = RSP_RUN_DONE;
        dist_d      = '0;
        hop_d       = '0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      u_q         <= '0;
      v_q         <= '0;
      w_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      u_q         <= u_d;
      v_q         <= v_d;
      w_q         <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvu_q       <= dvu_d;
    hvu_q       <= hvu_d;
    rd_inside_q <= rd_inside_d;
    rd_diag_q   <= rd_diag_d;
    kind_q      <= kind_d;
    dist_q      <= dist_d;
    hop_q       <= hop_d;
  end

  // --------------------------------------------------------------------------
  // distance and next-hop memories
  // --------------------------------------------------------------------------
  logic [WEIGHT_W-1:0] dist_mem [DEPTH];
  logic [VTX_W-1:0]    hop_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we) begin
      dist_mem[waddr] <= wdist;
      hop_mem[waddr]  <= whop;
    end
    rda_q <= dist_mem[ra];
    rha_q <= hop_mem[ra];
    rdb_q <= dist_mem[rb];
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_in_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (!out_valid_q || rsp_o.ready))
    else $error("item accepted while reply slot is blocked");

  a_run_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_i.req_type == REQ_RUN) |=> (state_q != ST_IDLE))
    else $error("run item did not start a sweep");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (w_q <= last_idx && v_q <= last_idx &&
                               u_q <= last_idx))
    else $error("sweep index beyond active vertices");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == ST_SWEEP) || (state_q == ST_IDLE && in_fire)))
    else $error("memory write outside load or sweep");

  a_reply_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (out_valid_q && kind_q == RSP_RUN_DONE))
    else $error("run finished without a reply");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the all-pairs shortest path block.
// ----------------------------------------------------------------------------
// Loads, relaxation runs and pair reads go in on the request channel. A
// cycle-accurate-free model of the distance and next-hop tables predicts
// every reply, and each reply is checked in order. Both channels idle and
// stall at random. The vertex count is changed over the APB port between
// phases, including 0 and values above the table size.
// ----------------------------------------------------------------------------
module tb;
  import apsp_pkg::*;

  localparam int MAX_V = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [APB_AW-1:0] VERTEX_COUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [VTX_W-1:0]    src;
    logic [VTX_W-1:0]    dst;
    logic [WEIGHT_W-1:0] weight;
  } path_request_t;

  typedef struct packed {
    rsp_e                kind;
    logic [WEIGHT_W-1:0] distance;
    logic [VTX_W-1:0]    hop;
  } path_reply_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  apsp_req_if req_if ();
  apsp_rsp_if rsp_if ();

  all_pairs_shortest_path_top #(
    .MAX_VERTICES(MAX_V)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // path tables as the block should hold them
  logic [WEIGHT_W-1:0] dist_model [MAX_V*MAX_V];
  logic [VTX_W-1:0]    hop_model  [MAX_V*MAX_V];
  logic [CNT_W-1:0]    vertex_count_model;

  // entries written so far, tracked at generation time
  bit was_loaded [MAX_V*MAX_V];

  path_request_t requests_queued [$];
  path_reply_t   replies_due [$];
  path_request_t req_next;
  path_reply_t   reply_want;

  int unsigned items_sent, items_taken;
  int unsigned loads_seen, runs_seen, reads_seen, unknown_seen;
  int unsigned replies_checked, error_count, count_settings;
  int unsigned req_gap, rsp_stall, stall_draw;
  int unsigned cycles;
  bit          req_calm, rsp_calm;

  function automatic void note_failure(input string what);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic void relax_paths();
    int unsigned n, u, v, w;
    logic [WEIGHT_W:0] via;
    n = (vertex_count_model > MAX_V) ? MAX_V : vertex_count_model;
    for (u = 0; u < n; u++) begin
      for (v = 0; v < n; v++) begin
        for (w = 0; w < n; w++) begin
          via = {1'b0, dist_model[v*MAX_V+u]} + {1'b0, dist_model[u*MAX_V+w]};
          if ({1'b0, dist_model[v*MAX_V+w]} > via) begin
            dist_model[v*MAX_V+w] = via[WEIGHT_W-1:0];
            hop_model[v*MAX_V+w]  = hop_model[v*MAX_V+u];
          end
        end
      end
    end
  endfunction

  function automatic void update_path_tables(input path_request_t req);
    path_reply_t reply;
    int unsigned at;
    at = req.src * MAX_V + req.dst;
    reply.kind     = RSP_LOAD_ACK;
    reply.distance = '0;
    reply.hop      = '0;
    case (req.kind)
      REQ_LOAD: begin
        dist_model[at] = (req.weight == '0) ? NO_EDGE : req.weight;
        hop_model[at]  = req.dst;
        loads_seen++;
        replies_due.push_back(reply);
      end
      REQ_RUN: begin
        relax_paths();
        reply.kind = RSP_RUN_DONE;
        runs_seen++;
        replies_due.push_back(reply);
      end
      REQ_READ: begin
        reply.kind     = RSP_READ;
        reply.distance = (req.src == req.dst) ? '0 : dist_model[at];
        reply.hop      = hop_model[at];
        reads_seen++;
        replies_due.push_back(reply);
      end
      default: unknown_seen++;
    endcase
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.req_type    <= '0;
      req_if.src_vertex  <= '0;
      req_if.dst_vertex  <= '0;
      req_if.edge_weight <= '0;
      req_gap            <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        update_path_tables({req_if.req_type, req_if.src_vertex, req_if.dst_vertex,
                            req_if.edge_weight});
        items_taken++;
      end
      if (req_gap != 0) begin
        req_gap      <= req_gap - 1;
        req_if.valid <= 1'b0;
      end else if (requests_queued.size() != 0) begin
        req_next = requests_queued.pop_front();
        req_if.valid       <= 1'b1;
        req_if.req_type    <= req_next.kind;
        req_if.src_vertex  <= req_next.src;
        req_if.dst_vertex  <= req_next.dst;
        req_if.edge_weight <= req_next.weight;
        req_gap            <= req_calm ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 39) == 0) req_calm <= !req_calm;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // reply monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall    <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      replies_checked++;
      if (replies_due.size() == 0) begin
        note_failure($sformatf("reply kind %0d with nothing outstanding", rsp_if.reply_kind));
      end else begin
        reply_want = replies_due.pop_front();
        if (rsp_if.reply_kind !== reply_want.kind ||
            rsp_if.path_distance !== reply_want.distance ||
            rsp_if.next_vertex !== reply_want.hop)
          note_failure($sformatf("kind %0d/%0d distance %0d/%0d hop %0d/%0d (exp/got)",
                                 reply_want.kind, rsp_if.reply_kind, reply_want.distance,
                                 rsp_if.path_distance, reply_want.hop, rsp_if.next_vertex));
      end
      stall_draw = rsp_calm ? 0 : $urandom_range(0, 7);
      rsp_stall    <= stall_draw;
      rsp_if.ready <= (stall_draw == 0);
      if ($urandom_range(0, 39) == 0) rsp_calm <= !rsp_calm;
    end else if (rsp_stall != 0) begin
      rsp_stall    <= rsp_stall - 1;
      rsp_if.ready <= (rsp_stall == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, replies_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic queue_request(input logic [REQ_W-1:0] kind, input int unsigned src,
                               input int unsigned dst, input logic [WEIGHT_W-1:0] weight);
    requests_queued.push_back({kind, src[VTX_W-1:0], dst[VTX_W-1:0], weight});
    if (kind == REQ_LOAD) was_loaded[src*MAX_V+dst] = 1'b1;
    items_sent++;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 25) return NO_EDGE;
    if (r < 65) return WEIGHT_W'($urandom_range(1, 20));
    if (r < 80) return WEIGHT_W'($urandom_range(1, 1000));
    if (r < 90) return WEIGHT_W'($urandom_range(32768, 65534));
    return WEIGHT_W'($urandom());
  endfunction

  // hold until every item is taken and every reply is in, then let ignored items drain
  task automatic wait_idle();
    while (items_taken != items_sent || replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VERTEX_COUNT_ADDR;
    pwdata  <= {{(APB_DW-CNT_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    vertex_count_model = value;
    // read back through a second transfer
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(APB_DW-CNT_W){1'b0}}, value})
      note_failure($sformatf("vertex count read back %0d, wrote %0d", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    count_settings++;
  endtask

  task automatic directed_checks();
    set_vertex_count(5'd3);
    // small graph: a strict tie on 0->2, relaxed paths on 1->0 and 2->1
    queue_request(REQ_LOAD, 0, 0, 16'd0);
    queue_request(REQ_LOAD, 0, 1, 16'd5);
    queue_request(REQ_LOAD, 0, 2, 16'd12);
    queue_request(REQ_LOAD, 1, 0, 16'd0);
    queue_request(REQ_LOAD, 1, 1, 16'd3);
    queue_request(REQ_LOAD, 1, 2, 16'd7);
    queue_request(REQ_LOAD, 2, 0, 16'd1);
    queue_request(REQ_LOAD, 2, 1, 16'd0);
    queue_request(REQ_LOAD, 2, 2, 16'd65534);
    queue_request(REQ_READ, 0, 2, 16'd0);
    queue_request(REQ_READ, 1, 1, 16'd0);
    queue_request(REQ_RUN, 0, 0, 16'd0);
    queue_request(REQ_READ, 0, 2, 16'd0);
    queue_request(REQ_READ, 1, 0, 16'd0);
    queue_request(REQ_READ, 2, 1, 16'd0);
    queue_request(REQ_READ, 2, 2, 16'd0);
    queue_request(REQ_UNKNOWN, 15, 15, 16'hFFFF);
    // corner vertices outside the active set
    queue_request(REQ_LOAD, 15, 15, NO_EDGE);
    queue_request(REQ_LOAD, 15, 0, 16'd1);
    queue_request(REQ_READ, 15, 15, 16'hFFFF);
    queue_request(REQ_READ, 15, 0, 16'd0);
    // a sum past 16 bits must not beat a missing edge
    queue_request(REQ_LOAD, 0, 1, 16'd40000);
    queue_request(REQ_LOAD, 1, 2, 16'd40000);
    queue_request(REQ_LOAD, 0, 2, 16'd0);
    queue_request(REQ_RUN, 0, 0, 16'd0);
    queue_request(REQ_READ, 0, 2, 16'd0);
    wait_idle();
  endtask

  task automatic random_phase(input logic [CNT_W-1:0] count, input int unsigned mixed_items);
    int unsigned n, r, s, d, v, w, k;
    n = (count > MAX_V) ? MAX_V : count;
    set_vertex_count(count);
    // a run may only touch written entries: fill the active square first
    for (v = 0; v < n; v++)
      for (w = 0; w < n; w++)
        if (!was_loaded[v*MAX_V+w]) queue_request(REQ_LOAD, v, w, pick_weight());
    for (k = 0; k < mixed_items; k++) begin
      r = $urandom_range(0, 99);
      if (n != 0 && $urandom_range(0, 3) != 0) begin
        s = $urandom_range(0, n - 1);
        d = $urandom_range(0, n - 1);
      end else begin
        s = $urandom_range(0, MAX_V - 1);
        d = $urandom_range(0, MAX_V - 1);
      end
      if (r < 40 || (r >= 46 && r < 94 && !was_loaded[s*MAX_V+d]))
        queue_request(REQ_LOAD, s, d, pick_weight());
      else if (r < 46)
        queue_request(REQ_RUN, s, d, WEIGHT_W'($urandom()));
      else if (r < 94)
        queue_request(REQ_READ, s, d, WEIGHT_W'($urandom()));
      else
        queue_request(REQ_UNKNOWN, s, d, WEIGHT_W'($urandom()));
    end
    wait_idle();
  endtask

  initial begin
    logic [CNT_W-1:0] phase_counts [10];
    int unsigned p;
    phase_counts = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd2, 5'd31, 5'd8, 5'd3, 5'd17, 5'd6};
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = '0;
    req_if.src_vertex  = '0;
    req_if.dst_vertex  = '0;
    req_if.edge_weight = '0;
    rsp_if.ready       = 1'b0;
    vertex_count_model = VERTEX_COUNT_RST;
    req_calm           = 1'b0;
    rsp_calm           = 1'b0;
    cycles             = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();
    for (p = 0; p < 10; p++) random_phase(phase_counts[p], 36);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (replies_due.size() != 0)
      note_failure($sformatf("%0d replies never arrived", replies_due.size()));

    $display("covered %0d loads, %0d runs, %0d reads, %0d ignored requests, %0d vertex counts",
             loads_seen, runs_seen, reads_seen, unknown_seen, count_settings);
    $display("%0d replies checked, %0d errors", replies_checked, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/apsp_pkg.sv
hw/rtl/apsp_req_if.sv
hw/rtl/apsp_rsp_if.sv
hw/rtl/all_pairs_shortest_path_top.sv
sim/tb.sv
